### rtl/asa_pkg.sv
// Shared widths, command and status codes, and scan result type for the slot allocator.
package asa_pkg;

  localparam int CMD_W    = 2;
  localparam int CLIENT_W = 8;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int REFS_W   = 16;
  localparam int MASK_W   = 16;

  localparam logic [MASK_W-1:0] PRESENT_RST = 16'h00FF;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNBIND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_BOUND = 3'd4;

  // per-entry outcome of the shared compare unit
  typedef struct packed {
    logic hit;      // entry is bound to the requesting client
    logic free;     // entry is unbound
    logic idle;     // entry count is zero
    logic slot_eq;  // entry slot number equals the target slot
  } scan_res_t;

endpackage

### rtl/asa_scan_unit.sv
// Shared compare unit: tests one slot table entry per cycle against client and target.
module asa_scan_unit
  import asa_pkg::*;
#(
  parameter int OW = 8,
  parameter int SW = 4
) (
  input  logic              ent_used,
  input  logic [OW-1:0]     ent_owner,
  input  logic [REFS_W-1:0] ent_refs,
  input  logic [SW-1:0]     ent_slot,
  input  logic [OW-1:0]     client,
  input  logic [SW-1:0]     target,
  output scan_res_t         res
);

  assign res.hit     = ent_used && (ent_owner == client);
  assign res.free    = !ent_used;
  assign res.idle    = (ent_refs == '0);
  assign res.slot_eq = (ent_slot == target);

endmodule

### rtl/address_space_slot_allocator_unit.sv
// Top level of the reference-counted address-space slot allocator.
// Binds client ids to SLOTS address-space slots with a reference count per binding.
// A single compare unit walks the slot table one entry per cycle to find the client's
// slot and the lowest free slot; an acquire that must evict, and an unbind, then walk
// the bind order one position per cycle through the same unit. The commit then
// updates the table and loads the output register; a reset-all skips both walks and
// goes straight to the commit. The input stalls while an item is in work; the output
// register lets a new item start while a result waits for transfer, and the commit
// waits only if the previous result is still held. present_mask is written over the
// cfg channel, which is always ready; write it only while idle.
module address_space_slot_allocator_unit
  import asa_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int CLIENT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [CLIENT_W-1:0] in_client,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status,
  output logic [CLIENT_W-1:0] out_evicted_client,
  output logic [REFS_W-1:0]   out_ref_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MASK_W-1:0]   cfg_present_mask
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int OW = (CLIENT_BITS < CLIENT_W) ? CLIENT_BITS : CLIENT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FIND   = 4'b0010,
    S_ORDER  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    A_INC, A_DEC, A_BIND, A_EVICT, A_UNBIND, A_NOSLOT, A_NOTBOUND, A_CLEAR
  } action_t;

  state_t            state_r, state_nxt;
  action_t           action_r, action_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [OW-1:0]     client_r;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     hit_r, hit_nxt;
  logic              free_ok_r, free_ok_nxt;
  logic [SW-1:0]     free_r, free_nxt;
  logic [SW-1:0]     sel_r, sel_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  logic              pos_ok_r, pos_ok_nxt;

  // slot table
  logic [SLOTS-1:0]  used_r;
  logic [OW-1:0]     owner_r [SLOTS];
  logic [REFS_W-1:0] refs_r [SLOTS];
  logic [SW-1:0]     order_r [SLOTS];
  logic [SW-1:0]     order_nxt [SLOTS];
  logic [LW-1:0]     len_r, len_nxt;
  logic [SLOTS-1:0]  present_r;

  // output register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CLIENT_W-1:0] out_evicted_r;
  logic [REFS_W-1:0]   out_refs_r;

  logic              in_fire, commit_fire, find_last, order_last, order_hit;
  logic [SW-1:0]     rd_slot;
  logic              ent_used;
  logic [OW-1:0]     ent_owner;
  logic [REFS_W-1:0] ent_refs;
  logic [REFS_W-1:0] refs_inc, refs_dec;
  logic              f_found, f_free_ok;
  logic [SW-1:0]     f_hit, f_free;
  scan_res_t         sres;

  assign in_stall    = (state_r != S_IDLE);
  assign in_fire     = in_valid && !in_stall;
  assign commit_fire = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  assign cfg_ready   = 1'b1;

  // one table read port; address follows the sequencer
  always_comb begin
    case (state_r)
      S_ORDER:  rd_slot = order_r[idx_r];
      S_COMMIT: rd_slot = sel_r;
      default:  rd_slot = idx_r;
    endcase
  end

  assign ent_used  = used_r[rd_slot];
  assign ent_owner = owner_r[rd_slot];
  assign ent_refs  = refs_r[rd_slot];

  asa_scan_unit #(
    .OW (OW),
    .SW (SW)
  ) u_scan (
    .ent_used  (ent_used),
    .ent_owner (ent_owner),
    .ent_refs  (ent_refs),
    .ent_slot  (rd_slot),
    .client    (client_r),
    .target    (sel_r),
    .res       (sres)
  );

  assign refs_inc = (&ent_refs) ? ent_refs : ent_refs + 1'b1;
  assign refs_dec = (ent_refs == '0) ? ent_refs : ent_refs - 1'b1;

  // scan results including the entry under test this cycle
  assign find_last = (idx_r == SW'(SLOTS - 1));
  assign f_found   = found_r || sres.hit;
  assign f_hit     = found_r ? hit_r : idx_r;
  assign f_free_ok = free_ok_r || sres.free;
  assign f_free    = free_ok_r ? free_r : idx_r;

  assign order_hit  = (action_r == A_EVICT) ? sres.idle : sres.slot_eq;
  assign order_last = ((LW'(idx_r) + LW'(1)) >= len_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    action_nxt  = action_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    hit_nxt     = hit_r;
    free_ok_nxt = free_ok_r;
    free_nxt    = free_r;
    sel_nxt     = sel_r;
    pos_nxt     = pos_r;
    pos_ok_nxt  = pos_ok_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        free_ok_nxt = 1'b0;
        pos_ok_nxt  = 1'b0;
        if (in_fire) begin
          if (in_command == CMD_CLEAR) begin
            action_nxt = A_CLEAR;
            state_nxt  = S_COMMIT;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (sres.hit && !found_r) begin
          found_nxt = 1'b1;
          hit_nxt   = idx_r;
        end
        if (sres.free && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_nxt    = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (find_last) begin
          idx_nxt   = '0;
          state_nxt = S_COMMIT;
          sel_nxt   = f_hit;
          case (cmd_r)
            CMD_ACQUIRE: begin
              if (f_found) begin
                action_nxt = A_INC;
              end else if (f_free_ok && present_r[f_free]) begin
                action_nxt = A_BIND;
                sel_nxt    = f_free;
              end else if (len_r == '0) begin
                action_nxt = A_NOSLOT;
              end else begin
                action_nxt = A_EVICT;
                state_nxt  = S_ORDER;
              end
            end
            CMD_RELEASE: begin
              action_nxt = f_found ? A_DEC : A_NOTBOUND;
            end
            default: begin
              if (f_found) begin
                action_nxt = A_UNBIND;
                if (len_r != '0) begin
                  state_nxt = S_ORDER;
                end
              end else begin
                action_nxt = A_NOTBOUND;
              end
            end
          endcase
        end
      end
      S_ORDER: begin
        idx_nxt = idx_r + 1'b1;
        if (order_hit) begin
          pos_nxt    = idx_r;
          pos_ok_nxt = 1'b1;
          state_nxt  = S_COMMIT;
          if (action_r == A_EVICT) begin
            sel_nxt = order_r[idx_r];
          end
        end else if (order_last) begin
          state_nxt = S_COMMIT;
          if (action_r == A_EVICT) begin
            action_nxt = A_NOSLOT;
          end
        end
      end
      S_COMMIT: begin
        if (commit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // bind order update: removal shifts younger entries down one place
  always_comb begin
    order_nxt = order_r;
    len_nxt   = len_r;
    if (commit_fire) begin
      case (action_r)
        A_BIND: begin
          order_nxt[len_r[SW-1:0]] = sel_r;
          len_nxt = len_r + 1'b1;
        end
        A_EVICT: begin
          for (int j = 0; j < SLOTS - 1; j++) begin
            if (LW'(j) >= LW'(pos_r) && LW'(j + 1) < len_r) begin
              order_nxt[j] = order_r[j + 1];
            end
          end
          order_nxt[SW'(len_r - LW'(1))] = sel_r;
        end
        A_UNBIND: begin
          if (pos_ok_r) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
              if (LW'(j) >= LW'(pos_r) && LW'(j + 1) < len_r) begin
                order_nxt[j] = order_r[j + 1];
              end
            end
            order_nxt[SW'(len_r - LW'(1))] = '0;
            len_nxt = len_r - 1'b1;
          end
        end
        A_CLEAR: len_nxt = '0;
        default: len_nxt = len_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      action_r    <= A_CLEAR;
      used_r      <= '0;
      len_r       <= '0;
      present_r   <= PRESENT_RST[SLOTS-1:0];
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      action_r <= action_nxt;
      len_r    <= len_nxt;
      if (cfg_valid && cfg_ready) begin
        present_r <= cfg_present_mask[SLOTS-1:0];
      end
      if (commit_fire) begin
        out_valid_r <= 1'b1;
        case (action_r)
          A_BIND, A_EVICT: used_r[sel_r] <= 1'b1;
          A_UNBIND:        used_r[sel_r] <= 1'b0;
          A_CLEAR:         used_r <= '0;
          default:         used_r <= used_r;
        endcase
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers and table payload
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    hit_r     <= hit_nxt;
    free_ok_r <= free_ok_nxt;
    free_r    <= free_nxt;
    sel_r     <= sel_nxt;
    pos_r     <= pos_nxt;
    pos_ok_r  <= pos_ok_nxt;
    order_r   <= order_nxt;
    if (in_fire) begin
      cmd_r    <= in_command;
      client_r <= in_client[OW-1:0];
    end
    if (commit_fire) begin
      case (action_r)
        A_INC: begin
          refs_r[sel_r] <= refs_inc;
          out_slot_r    <= SLOT_W'(sel_r);
          out_status_r  <= ST_DONE;
          out_evicted_r <= '0;
          out_refs_r    <= refs_inc;
        end
        A_DEC: begin
          refs_r[sel_r] <= refs_dec;
          out_slot_r    <= SLOT_W'(sel_r);
          out_status_r  <= ST_DONE;
          out_evicted_r <= '0;
          out_refs_r    <= refs_dec;
        end
        A_BIND: begin
          owner_r[sel_r] <= client_r;
          refs_r[sel_r]  <= REFS_W'(1);
          out_slot_r     <= SLOT_W'(sel_r);
          out_status_r   <= ST_NEW;
          out_evicted_r  <= '0;
          out_refs_r     <= REFS_W'(1);
        end
        A_EVICT: begin
          owner_r[sel_r] <= client_r;
          refs_r[sel_r]  <= REFS_W'(1);
          out_slot_r     <= SLOT_W'(sel_r);
          out_status_r   <= ST_EVICT;
          out_evicted_r  <= CLIENT_W'(ent_owner);
          out_refs_r     <= REFS_W'(1);
        end
        A_UNBIND: begin
          owner_r[sel_r] <= '0;
          refs_r[sel_r]  <= '0;
          out_slot_r     <= '0;
          out_status_r   <= ST_DONE;
          out_evicted_r  <= '0;
          out_refs_r     <= '0;
        end
        A_NOSLOT: begin
          out_slot_r    <= '0;
          out_status_r  <= ST_NO_SLOT;
          out_evicted_r <= '0;
          out_refs_r    <= '0;
        end
        A_NOTBOUND: begin
          out_slot_r    <= '0;
          out_status_r  <= ST_NOT_BOUND;
          out_evicted_r <= '0;
          out_refs_r    <= '0;
        end
        default: begin
          out_slot_r    <= '0;
          out_status_r  <= ST_DONE;
          out_evicted_r <= '0;
          out_refs_r    <= '0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_status         = out_status_r;
  assign out_evicted_client = out_evicted_r;
  assign out_ref_count      = out_refs_r;

endmodule
